@@ hdl/utf8_window_decoder_defines.svh @@
// Assertion macros used by the UTF-8 window decoder top level.
`ifndef UTF8_WINDOW_DECODER_DEFINES_SVH
`define UTF8_WINDOW_DECODER_DEFINES_SVH

// Same-cycle implication, checked only outside reset.
`define U8WD_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u8wd assertion failed: same-cycle implication");

// Next-cycle implication, checked only outside reset.
`define U8WD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u8wd assertion failed: next-cycle implication");

`endif

@@ hdl/u8wd_pkg.sv @@
// Types, status codes and lead-byte classification for the UTF-8 window decoder.
`default_nettype none

package u8wd_pkg;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TRUNC   = 2'd1,
        ST_BADCONT = 2'd2,
        ST_BADLEAD = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] lead_byte;
        logic [7:0] second_byte;
        logic [7:0] third_byte;
        logic [7:0] fourth_byte;
        logic [2:0] bytes_available;
    } window_t;

    typedef struct packed {
        logic [20:0] code_point;
        logic [2:0]  bytes_used;
        status_t     status;
    } result_t;

    localparam logic [2:0] MAX_BYTES = 3'd4;

    // Sequence length from the top five bits of the lead byte; 0 marks a bad lead.
    function automatic logic [2:0] lead_len(input logic [4:0] top);
        logic [2:0] len;
        begin
            if (top[4] == 1'b0)
            begin
                len = 3'd1;
            end
            else if (top[4:2] == 3'b110)
            begin
                len = 3'd2;
            end
            else if (top[4:1] == 4'b1110)
            begin
                len = 3'd3;
            end
            else if (top == 5'b11110)
            begin
                len = 3'd4;
            end
            else
            begin
                len = 3'd0;
            end
            return len;
        end
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

endpackage

`default_nettype wire

@@ hdl/u8wd_decode.sv @@
// Combinational decode of one registered byte window into a code point and status.
`default_nettype none

module u8wd_decode (
    input  u8wd_pkg::window_t window,
    output u8wd_pkg::result_t result
);

    logic [2:0] seq_len;
    logic [2:0] avail;
    logic       c1;
    logic       c2;
    logic       c3;

    always_comb
    begin
        seq_len = u8wd_pkg::lead_len(window.lead_byte[7:3]);
        // clamp counts of five to seven down to four
        avail   = window.bytes_available[2] ? u8wd_pkg::MAX_BYTES : window.bytes_available;
        c1      = u8wd_pkg::is_cont(window.second_byte);
        c2      = u8wd_pkg::is_cont(window.third_byte);
        c3      = u8wd_pkg::is_cont(window.fourth_byte);

        result.code_point = 21'd0;
        result.bytes_used = 3'd0;
        result.status     = u8wd_pkg::ST_OK;

        priority if (seq_len == 3'd0)
        begin
            result.status = u8wd_pkg::ST_BADLEAD;
        end
        else if (avail < seq_len)
        begin
            result.status = u8wd_pkg::ST_TRUNC;
        end
        else
        begin
            unique case (seq_len)
                3'd1:
                begin
                    result.code_point = {13'd0, window.lead_byte};
                    result.bytes_used = seq_len;
                end
                3'd2:
                begin
                    if (!c1)
                    begin
                        result.status = u8wd_pkg::ST_BADCONT;
                    end
                    else
                    begin
                        result.code_point = {10'd0, window.lead_byte[4:0],
                                             window.second_byte[5:0]};
                        result.bytes_used = seq_len;
                    end
                end
                3'd3:
                begin
                    if (!(c1 && c2))
                    begin
                        result.status = u8wd_pkg::ST_BADCONT;
                    end
                    else
                    begin
                        result.code_point = {5'd0, window.lead_byte[3:0],
                                             window.second_byte[5:0],
                                             window.third_byte[5:0]};
                        result.bytes_used = seq_len;
                    end
                end
                3'd4:
                begin
                    if (!(c1 && c2 && c3))
                    begin
                        result.status = u8wd_pkg::ST_BADCONT;
                    end
                    else
                    begin
                        result.code_point = {window.lead_byte[2:0],
                                             window.second_byte[5:0],
                                             window.third_byte[5:0],
                                             window.fourth_byte[5:0]};
                        result.bytes_used = seq_len;
                    end
                end
                default:
                begin
                    result.status = u8wd_pkg::ST_BADLEAD;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hdl/utf8_window_decoder.sv @@
// Top level of the UTF-8 window decoder: input register, decode, result register.
// A window is held in the input register and its result, with done, in the result register.
// Throughput: one window per cycle; busy stays low, so start may be held every cycle.
// The decode is one pass of lead classification, continuation checks and bit packing.
// The receiver cannot stall: done is high for a single cycle per result; the result ports hold the last one.
// Reset (rst_n low, asynchronous) clears both valid flags; a result in flight is lost, none is made.
`default_nettype none

`include "utf8_window_decoder_defines.svh"

module utf8_window_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  lead_byte,
    input  logic [7:0]  second_byte,
    input  logic [7:0]  third_byte,
    input  logic [7:0]  fourth_byte,
    input  logic [2:0]  bytes_available,
    output logic        done,
    output logic [20:0] code_point,
    output logic [2:0]  bytes_used,
    output logic [1:0]  status
);

    // input stage: one transaction per cycle, no back-pressure
    logic               in_valid_reg;
    logic               in_valid_next;
    u8wd_pkg::window_t  window_reg;
    u8wd_pkg::window_t  window_next;

    // result stage
    logic               done_reg;
    logic               done_next;
    u8wd_pkg::result_t  result_reg;
    u8wd_pkg::result_t  result_next;

    u8wd_pkg::result_t  decoded;

    // The pipeline never backs up, so start is always taken.
    assign busy = 1'b0;

    always_comb
    begin
        in_valid_next = start && !busy;
        window_next   = window_reg;
        if (in_valid_next)
        begin
            // capture the window only for a new transaction
            window_next.lead_byte       = lead_byte;
            window_next.second_byte     = second_byte;
            window_next.third_byte      = third_byte;
            window_next.fourth_byte     = fourth_byte;
            window_next.bytes_available = bytes_available;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        window_reg <= window_next;
    end

    // classify the lead, check continuations, pack the code point
    u8wd_decode u_decode (
        .window (window_reg),
        .result (decoded)
    );

    always_comb
    begin
        done_next   = in_valid_reg;
        // hold the last result when idle
        result_next = in_valid_reg ? decoded : result_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done       = done_reg;
    assign code_point = result_reg.code_point;
    assign bytes_used = result_reg.bytes_used;
    assign status     = result_reg.status;

    // result field checks used by the assertions below
    logic err_zeroed;
    logic used_legal;

    assign err_zeroed = (code_point == 21'd0) && (bytes_used == 3'd0);
    assign used_legal = (bytes_used != 3'd0) && (bytes_used <= u8wd_pkg::MAX_BYTES);

    // every window in the decode stage leaves the result stage in the next cycle
    `U8WD_ASSERT_NEXT(a_window_reaches_result, in_valid_reg, done)
    // a strobe only follows a window in the decode stage
    `U8WD_ASSERT_IMPLIES(a_done_has_source, done, $past(in_valid_reg))
    // errors report zero code point and zero bytes used
    `U8WD_ASSERT_IMPLIES(a_error_zeroes, done && (status != u8wd_pkg::ST_OK), err_zeroed)
    // a good decode consumes one to four bytes
    `U8WD_ASSERT_IMPLIES(a_ok_length, done && (status == u8wd_pkg::ST_OK), used_legal)

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for the UTF-8 window decoder: directed windows, then random ones.
module testbench;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_LIMIT   = 64;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_PER_PHASE = 133;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [7:0]  lead_byte = 8'd0;
    logic [7:0]  second_byte = 8'd0;
    logic [7:0]  third_byte = 8'd0;
    logic [7:0]  fourth_byte = 8'd0;
    logic [2:0]  bytes_available = 3'd0;
    logic        done;
    logic [20:0] code_point;
    logic [2:0]  bytes_used;
    logic [1:0]  status;

    // Decoded results still owed by the block, oldest first.
    u8wd_pkg::result_t pending_results[$];
    int      fail_count = 0;
    int      report_count = 0;
    int      cycle_count = 0;
    // Percent chance that the sender idles before each transaction, drawn anew after each idle.
    int      sender_idle_pct = 0;

    utf8_window_decoder dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .lead_byte       (lead_byte),
        .second_byte     (second_byte),
        .third_byte      (third_byte),
        .fourth_byte     (fourth_byte),
        .bytes_available (bytes_available),
        .done            (done),
        .code_point      (code_point),
        .bytes_used      (bytes_used),
        .status          (status)
    );

    always #CLK_HALF clk = ~clk;

    // Watchdog: a hung handshake or a lost result ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Decode one window: classify the lead by its top five bits, clamp the
    // byte count at four, check for truncation before any continuation byte
    // is looked at, then pack the payload bits. Every error gives zero
    // code point and zero bytes used.
    function automatic u8wd_pkg::result_t decode_window(input u8wd_pkg::window_t w);
        u8wd_pkg::result_t r;
        logic [2:0] seq_len;
        logic [2:0] avail;
        logic       cont1;
        logic       cont2;
        logic       cont3;
        r.code_point = '0;
        r.bytes_used = '0;
        r.status     = u8wd_pkg::ST_OK;
        casez (w.lead_byte[7:3])
            5'b0????: seq_len = 3'd1;
            5'b110??: seq_len = 3'd2;
            5'b1110?: seq_len = 3'd3;
            5'b11110: seq_len = 3'd4;
            default:  seq_len = 3'd0;
        endcase
        avail = (w.bytes_available > u8wd_pkg::MAX_BYTES) ? u8wd_pkg::MAX_BYTES
                                                          : w.bytes_available;
        cont1 = (w.second_byte[7:6] == 2'b10);
        cont2 = (w.third_byte[7:6] == 2'b10);
        cont3 = (w.fourth_byte[7:6] == 2'b10);
        if (seq_len == 3'd0)
        begin
            r.status = u8wd_pkg::ST_BADLEAD;
        end
        else if (avail < seq_len)
        begin
            r.status = u8wd_pkg::ST_TRUNC;
        end
        else
        begin
            case (seq_len)
                3'd1:
                begin
                    r.code_point = {13'd0, w.lead_byte};
                end
                3'd2:
                begin
                    if (!cont1)
                    begin
                        r.status = u8wd_pkg::ST_BADCONT;
                    end
                    r.code_point = {10'd0, w.lead_byte[4:0], w.second_byte[5:0]};
                end
                3'd3:
                begin
                    if (!cont1 || !cont2)
                    begin
                        r.status = u8wd_pkg::ST_BADCONT;
                    end
                    r.code_point = {5'd0, w.lead_byte[3:0], w.second_byte[5:0],
                                    w.third_byte[5:0]};
                end
                default:
                begin
                    if (!cont1 || !cont2 || !cont3)
                    begin
                        r.status = u8wd_pkg::ST_BADCONT;
                    end
                    r.code_point = {w.lead_byte[2:0], w.second_byte[5:0],
                                    w.third_byte[5:0], w.fourth_byte[5:0]};
                end
            endcase
            if (r.status == u8wd_pkg::ST_OK)
            begin
                r.bytes_used = seq_len;
            end
            else
            begin
                r.code_point = '0;
            end
        end
        return r;
    endfunction

    // Build a random window. Most are well-formed sequences with random
    // payload bits; the rest break one continuation byte, cut the count
    // short, or are pure noise. Bytes past the sequence stay random.
    function automatic u8wd_pkg::window_t random_window();
        u8wd_pkg::window_t w;
        int          kind;
        int          seq_len;
        int          pick;
        logic [31:0] rnd;
        logic [7:0]  bad;
        rnd = $urandom;
        w.lead_byte       = rnd[7:0];
        w.second_byte     = rnd[15:8];
        w.third_byte      = rnd[23:16];
        w.fourth_byte     = rnd[31:24];
        w.bytes_available = 3'($urandom_range(7));
        kind = $urandom_range(99);
        if (kind < 85)
        begin
            if (kind >= 60 && kind < 75)
            begin
                seq_len = $urandom_range(2, 4);
            end
            else
            begin
                seq_len = $urandom_range(1, 4);
            end
            rnd = $urandom;
            case (seq_len)
                1: w.lead_byte = {1'b0, rnd[6:0]};
                2: w.lead_byte = {3'b110, rnd[4:0]};
                3: w.lead_byte = {4'b1110, rnd[3:0]};
                default: w.lead_byte = {5'b11110, rnd[2:0]};
            endcase
            if (seq_len >= 2)
            begin
                w.second_byte = {2'b10, rnd[13:8]};
            end
            if (seq_len >= 3)
            begin
                w.third_byte = {2'b10, rnd[21:16]};
            end
            if (seq_len >= 4)
            begin
                w.fourth_byte = {2'b10, rnd[29:24]};
            end
            if (kind < 60)
            begin
                w.bytes_available = 3'($urandom_range(seq_len, 7));
            end
            else if (kind < 75)
            begin
                // Corrupt one needed byte so its top bits are no longer 10.
                bad = 8'($urandom);
                if (bad[7:6] == 2'b10)
                begin
                    bad[6] = 1'b1;
                end
                pick = $urandom_range(1, seq_len - 1);
                case (pick)
                    1: w.second_byte = bad;
                    2: w.third_byte = bad;
                    default: w.fourth_byte = bad;
                endcase
                w.bytes_available = 3'($urandom_range(seq_len, 7));
            end
            else
            begin
                w.bytes_available = 3'($urandom_range(0, seq_len - 1));
            end
        end
        return w;
    endfunction

    // Send one window: sit out random cycles, drive at the falling edge,
    // hold start until a rising edge sees busy low, then log the expected
    // result for that transaction.
    task automatic send_window(input logic [7:0] b0, input logic [7:0] b1,
                               input logic [7:0] b2, input logic [7:0] b3,
                               input logic [2:0] avail);
        u8wd_pkg::window_t w;
        w.lead_byte       = b0;
        w.second_byte     = b1;
        w.third_byte      = b2;
        w.fourth_byte     = b3;
        w.bytes_available = avail;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        lead_byte       <= b0;
        second_byte     <= b1;
        third_byte      <= b2;
        fourth_byte     <= b3;
        bytes_available <= avail;
        start           <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        pending_results.push_back(decode_window(w));
    endtask

    // Drop start, then wait (bounded) until every owed result has come back.
    task automatic wait_for_drain();
        int waited;
        waited = 0;
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_results.size() != 0)
        begin
            fail_count++;
            if (report_count < MAX_REPORTS)
            begin
                report_count++;
                $display("error: %0d results never arrived", pending_results.size());
            end
            pending_results.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_random_windows(input int count, input int idle_pct);
        u8wd_pkg::window_t w;
        sender_idle_pct = idle_pct;
        repeat (count)
        begin
            w = random_window();
            send_window(w.lead_byte, w.second_byte, w.third_byte, w.fourth_byte,
                        w.bytes_available);
        end
    endtask

    // Field extremes, every lead class, and each error path.
    task automatic test_directed_cases();
        sender_idle_pct = 0;
        send_window(8'h00, 8'h00, 8'h00, 8'h00, 3'd1);
        send_window(8'h7F, 8'hFF, 8'hFF, 8'hFF, 3'd4);
        // ASCII lead with nothing available still counts as truncated.
        send_window(8'h41, 8'h80, 8'h80, 8'h80, 3'd0);
        // Overlong and surrogate forms pass; no range checks are made.
        send_window(8'hC0, 8'h80, 8'h00, 8'h00, 3'd2);
        send_window(8'hDF, 8'hBF, 8'hFF, 8'hFF, 3'd2);
        send_window(8'hE0, 8'h80, 8'h80, 8'h00, 3'd3);
        send_window(8'hEF, 8'hBF, 8'hBF, 8'hFF, 3'd3);
        send_window(8'hED, 8'hA0, 8'h80, 8'h00, 3'd3);
        send_window(8'hF0, 8'h80, 8'h80, 8'h80, 3'd4);
        send_window(8'hF7, 8'hBF, 8'hBF, 8'hBF, 3'd4);
        // Counts above four clamp to four.
        send_window(8'hF4, 8'h8F, 8'hBF, 8'hBF, 3'd5);
        send_window(8'hF0, 8'h9F, 8'h98, 8'h80, 3'd7);
        // Continuation bytes and 11111xxx as lead, at any count.
        send_window(8'h80, 8'h80, 8'h80, 8'h80, 3'd4);
        send_window(8'hBF, 8'h00, 8'h00, 8'h00, 3'd0);
        send_window(8'hF8, 8'h80, 8'h80, 8'h80, 3'd4);
        send_window(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd7);
        // Truncation wins over junk past the available bytes.
        send_window(8'hC2, 8'h00, 8'h00, 8'h00, 3'd1);
        send_window(8'hE2, 8'h82, 8'hFF, 8'h00, 3'd2);
        send_window(8'hF0, 8'h90, 8'h80, 8'h41, 3'd3);
        // Bad continuation, including 11111xxx in a trailing slot.
        send_window(8'hC2, 8'h41, 8'h00, 8'h00, 3'd2);
        send_window(8'hE2, 8'h82, 8'hC0, 8'h00, 3'd3);
        send_window(8'hF0, 8'h90, 8'h80, 8'hF8, 3'd4);
        send_window(8'hC3, 8'h00, 8'h80, 8'h80, 3'd4);
        wait_for_drain();
    endtask

    task automatic test_light_sender_gaps();
        run_random_windows(RANDOM_PER_PHASE, 19);
        wait_for_drain();
    endtask

    task automatic test_heavy_sender_gaps();
        run_random_windows(RANDOM_PER_PHASE, 56);
        wait_for_drain();
    endtask

    task automatic test_back_to_back();
        run_random_windows(RANDOM_PER_PHASE, 0);
        wait_for_drain();
    endtask

    // Compare each result against the oldest owed transaction.
    always @(posedge clk)
    begin : check_results
        u8wd_pkg::result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (report_count < MAX_REPORTS)
                begin
                    report_count++;
                    $display("error: result cp=%h used=%0d status=%0d",
                             code_point, bytes_used, status,
                             " with no pending transaction");
                end
            end
            else
            begin
                want = pending_results.pop_front();
                if (code_point !== want.code_point || bytes_used !== want.bytes_used ||
                    status !== want.status)
                begin
                    fail_count++;
                    if (report_count < MAX_REPORTS)
                    begin
                        report_count++;
                        $display("mismatch: expected cp=%h used=%0d status=%0d,",
                                 want.code_point, want.bytes_used, want.status,
                                 " got cp=%h used=%0d status=%0d",
                                 code_point, bytes_used, status);
                    end
                end
            end
        end
    end

    initial
    begin
        // Hold reset for a fixed stretch, release away from the rising edge.
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_light_sender_gaps();
        test_heavy_sender_gaps();
        test_back_to_back();

        if (fail_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
